// ===== sv/wsvs_pkg.sv =====
// ----------------------------------------------------------------------------
// wsvs_pkg: shared types and constants for the WAV stream volume scaler
// Parse phases, header magic words, fixed header offsets and the result entry.
// ----------------------------------------------------------------------------
`default_nettype none

package wsvs_pkg;

  // Parser phases
  typedef enum logic [2:0] {
    PH_HEADER = 3'd0,
    PH_EXT    = 3'd1,
    PH_SIZE   = 3'd2,
    PH_DATA   = 3'd3,
    PH_PASS   = 3'd4,
    PH_ERROR  = 3'd5
  } phase_t;

  // Little-endian magic words as they sit in the four-byte history
  localparam logic [31:0] MAGIC_RIFF = 32'h4646_4952;
  localparam logic [31:0] MAGIC_WAVE = 32'h4556_4157;
  localparam logic [31:0] MAGIC_DATA = 32'h6174_6164;
  localparam logic [31:0] MAGIC_FACT = 32'h7463_6166;

  localparam int unsigned POS_W = 17;
  localparam logic [POS_W-1:0] POS_MAX = '1;

  // Header byte offsets
  localparam logic [POS_W-1:0] POS_RIFF_END  = 17'd3;
  localparam logic [POS_W-1:0] POS_WAVE_END  = 17'd11;
  localparam logic [POS_W-1:0] POS_TAG_END   = 17'd21;
  localparam logic [POS_W-1:0] POS_BITS_END  = 17'd35;
  localparam logic [POS_W-1:0] POS_CHUNK_END = 17'd39;
  localparam logic [POS_W-1:0] SIZE_AT_DATA  = 17'd40;
  localparam logic [POS_W-1:0] SIZE_AT_FACT  = 17'd52;
  localparam logic [POS_W-1:0] EXT_CHUNK_END = 17'd41;
  localparam logic [POS_W-1:0] EXT_AT_DATA   = 17'd42;
  localparam logic [POS_W-1:0] EXT_AT_FACT   = 17'd54;
  localparam logic [POS_W-1:0] SIZE_LEN_M1   = 17'd3;

  localparam logic [15:0] FMT_PCM    = 16'd1;
  localparam logic [15:0] VOL_RESET  = 16'd256;

  // One queued result
  typedef struct packed {
    logic [7:0] data;
    logic       err;
    logic       last;
  } res_t;

endpackage

`default_nettype wire

// ===== sv/wav_stream_volume_scaler.sv =====
// ----------------------------------------------------------------------------
// wav_stream_volume_scaler: WAV byte stream parser with PCM volume scaling
// Echoes non-sample bytes, tracks the header, scales 8-bit or 16-bit samples.
// ----------------------------------------------------------------------------
//  Channel   Dir  Handshake              Payload
//  s_axis    in   tvalid/tready          tdata = in_byte, tuser = first_of_file
//  m_axis    out  tvalid/tready          tdata = out_byte, tuser = header_error,
//                                        tlast = last
//  cfg       in   cfg_valid/cfg_ready    cfg_data = volume (always ready)
//
//  One byte per cycle when not stalled: input register, one 17x17 multiply, result queue.
//  Each byte is registered before its results are written into the queue.
//  A 16-bit pair gives no result on its first byte and two on its second.
//  The four-entry result queue decouples the sides; input stalls when it
//  holds more than two entries. Synchronous reset clears parser and queue.
// ----------------------------------------------------------------------------
`default_nettype none

module wav_stream_volume_scaler (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] in_byte
  input  wire logic [0:0]  s_axis_tuser,   // [0] first_of_file
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [7:0]       m_axis_tdata,   // [7:0] out_byte
  output logic [0:0]       m_axis_tuser,   // [0] header_error
  output logic             m_axis_tlast,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [15:0] cfg_data
);

  import wsvs_pkg::*;

  // Volume register
  logic [15:0] volume;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      volume <= VOL_RESET;
    end else if (cfg_valid) begin
      volume <= cfg_data;
    end
  end

  // Input register
  logic       in_valid;
  logic [7:0] in_byte_q;
  logic       in_first_q;
  logic       advance;
  logic [2:0] count;

  assign advance       = in_valid && (count <= 3'd2);
  assign s_axis_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte_q  <= s_axis_tdata;
      in_first_q <= s_axis_tuser[0];
    end
  end

  // Parser state
  logic [POS_W-1:0] byte_position, byte_position_next;
  phase_t           phase, phase_next;
  logic [31:0]      recent_bytes, recent_bytes_next;
  logic [15:0]      sample_bits, sample_bits_next;
  logic [15:0]      extension_length, extension_length_next;
  logic [POS_W-1:0] size_field_start, size_field_start_next;
  logic [31:0]      bytes_remaining, bytes_remaining_next;
  logic [7:0]       held_low_byte, held_low_byte_next;
  logic             pair_half, pair_half_next;

  // State as seen by this byte (a file start restarts the parser)
  logic [POS_W-1:0] c_pos;
  phase_t           c_phase;
  logic [31:0]      c_recent;
  logic [15:0]      c_bits;
  logic [15:0]      c_ext;
  logic [POS_W-1:0] c_sfs;
  logic [31:0]      c_rem;
  logic             c_half;
  logic             eight_bit;
  logic [POS_W-1:0] ext_end;

  always_comb begin
    c_pos    = in_first_q ? '0 : byte_position;
    c_phase  = in_first_q ? PH_HEADER : phase;
    c_recent = in_first_q ? '0 : recent_bytes;
    c_bits   = in_first_q ? '0 : sample_bits;
    c_ext    = in_first_q ? '0 : extension_length;
    c_sfs    = in_first_q ? '0 : size_field_start;
    c_rem    = in_first_q ? '0 : bytes_remaining;
    c_half   = in_first_q ? 1'b0 : pair_half;
  end

  assign eight_bit = (c_bits[15:3] == 13'd1);
  assign ext_end   = {1'b0, c_ext} + EXT_CHUNK_END;

  // Shared sample multiplier: 8-bit offset sample or signed 16-bit pair
  logic signed [16:0] mul_a;
  logic signed [16:0] mul_b;
  logic signed [33:0] prod;
  logic signed [33:0] prod_adj;
  logic [8:0]         x_off;
  logic [7:0]         scaled8;
  logic [15:0]        scaled16;

  assign x_off = {1'b0, in_byte_q} - 9'd128;

  always_comb begin
    if (eight_bit) begin
      mul_a = {{8{x_off[8]}}, x_off};
    end else begin
      mul_a = {in_byte_q[7], in_byte_q, held_low_byte};
    end
    mul_b = {1'b0, volume};
  end

  assign prod = 34'(mul_a) * 34'(mul_b);

  // Floor shift by 7, then +128 mod 256 flips the top bit
  assign scaled8  = prod[14:7] ^ 8'h80;
  // Divide by 256 toward zero: bias negatives by 255 before the shift
  assign prod_adj = prod + (prod[33] ? 34'sd255 : 34'sd0);
  assign scaled16 = prod_adj[23:8];

  // Next state and results
  logic [1:0] n_out;
  res_t       res0, res1;

  always_comb begin
    recent_bytes_next     = {in_byte_q, c_recent[31:8]};
    byte_position_next    = (c_pos != POS_MAX) ? c_pos + 1'b1 : c_pos;
    phase_next            = c_phase;
    sample_bits_next      = c_bits;
    extension_length_next = c_ext;
    size_field_start_next = c_sfs;
    bytes_remaining_next  = c_rem;
    held_low_byte_next    = held_low_byte;
    pair_half_next        = c_half;
    n_out                 = 2'd1;
    res0.data             = in_byte_q;
    res0.err              = 1'b0;
    res0.last             = 1'b1;
    res1.data             = scaled16[15:8];
    res1.err              = 1'b0;
    res1.last             = 1'b1;

    unique case (c_phase)
      PH_HEADER: begin
        if (c_pos == POS_RIFF_END && recent_bytes_next != MAGIC_RIFF) begin
          phase_next = PH_ERROR;
        end else if (c_pos == POS_WAVE_END && recent_bytes_next != MAGIC_WAVE) begin
          phase_next = PH_ERROR;
        end else if (c_pos == POS_TAG_END && recent_bytes_next[31:16] != FMT_PCM) begin
          phase_next = PH_PASS;
        end else if (c_pos == POS_BITS_END) begin
          sample_bits_next = recent_bytes_next[31:16];
        end else if (c_pos == POS_CHUNK_END) begin
          if (recent_bytes_next == MAGIC_DATA) begin
            size_field_start_next = SIZE_AT_DATA;
            phase_next            = PH_SIZE;
          end else if (recent_bytes_next == MAGIC_FACT) begin
            size_field_start_next = SIZE_AT_FACT;
            phase_next            = PH_SIZE;
          end else begin
            extension_length_next = recent_bytes_next[15:0];
            phase_next            = PH_EXT;
          end
        end
      end
      PH_EXT: begin
        if (c_pos == ext_end) begin
          if (recent_bytes_next == MAGIC_DATA) begin
            size_field_start_next = {1'b0, c_ext} + EXT_AT_DATA;
            phase_next            = PH_SIZE;
          end else if (recent_bytes_next == MAGIC_FACT) begin
            size_field_start_next = {1'b0, c_ext} + EXT_AT_FACT;
            phase_next            = PH_SIZE;
          end else begin
            bytes_remaining_next = recent_bytes_next;
            pair_half_next       = 1'b0;
            phase_next           = (recent_bytes_next == '0) ? PH_PASS : PH_DATA;
          end
        end
      end
      PH_SIZE: begin
        if (c_pos == c_sfs + SIZE_LEN_M1) begin
          bytes_remaining_next = recent_bytes_next;
          pair_half_next       = 1'b0;
          phase_next           = (recent_bytes_next == '0) ? PH_PASS : PH_DATA;
        end
      end
      PH_DATA: begin
        if (eight_bit) begin
          res0.data            = scaled8;
          bytes_remaining_next = c_rem - 1'b1;
          if (bytes_remaining_next == '0) begin
            phase_next = PH_PASS;
          end
        end else if (!c_half) begin
          // first byte of a pair: hold it, no result
          held_low_byte_next   = in_byte_q;
          pair_half_next       = 1'b1;
          bytes_remaining_next = c_rem - 1'b1;
          n_out                = 2'd0;
        end else begin
          pair_half_next = 1'b0;
          if (c_rem != '0) begin
            bytes_remaining_next = c_rem - 1'b1;
          end
          if (bytes_remaining_next == '0) begin
            phase_next = PH_PASS;
          end
          n_out     = 2'd2;
          res0.data = scaled16[7:0];
          res0.last = 1'b0;
        end
      end
      PH_PASS, PH_ERROR: begin
      end
      default: begin
      end
    endcase

    if (n_out == 2'd1) begin
      res0.err = (phase_next == PH_ERROR);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position    <= '0;
      phase            <= PH_HEADER;
      recent_bytes     <= '0;
      sample_bits      <= '0;
      extension_length <= '0;
      size_field_start <= '0;
      bytes_remaining  <= '0;
      held_low_byte    <= '0;
      pair_half        <= 1'b0;
    end else if (advance) begin
      byte_position    <= byte_position_next;
      phase            <= phase_next;
      recent_bytes     <= recent_bytes_next;
      sample_bits      <= sample_bits_next;
      extension_length <= extension_length_next;
      size_field_start <= size_field_start_next;
      bytes_remaining  <= bytes_remaining_next;
      held_low_byte    <= held_low_byte_next;
      pair_half        <= pair_half_next;
    end
  end

  // Result queue, four entries, up to two pushes per cycle
  res_t       queue [4];
  logic [1:0] wr_ptr, rd_ptr;
  logic [1:0] push_n;
  logic       pop;
  res_t       head;

  assign push_n = advance ? n_out : 2'd0;
  assign pop    = m_axis_tvalid && m_axis_tready;

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      queue[wr_ptr] <= res0;
    end
    if (push_n == 2'd2) begin
      queue[wr_ptr + 2'd1] <= res1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + push_n;
      rd_ptr <= rd_ptr + {1'b0, pop};
      count  <= count + {1'b0, push_n} - {2'b00, pop};
    end
  end

  assign head            = queue[rd_ptr];
  assign m_axis_tvalid   = (count != 3'd0);
  assign m_axis_tdata    = head.data;
  assign m_axis_tuser[0] = head.err;
  assign m_axis_tlast    = head.last;

  // Checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= 3'd4)
    else $error("result queue overflow");

  a_pair_complete: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tlast) |-> count >= 3'd2)
    else $error("low byte of pair queued without its high byte");

  a_half_in_data: assert property (@(posedge clk) disable iff (rst)
    pair_half |-> phase == PH_DATA)
    else $error("pair half held outside data phase");

  a_rem_nonzero: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_DATA && !pair_half) |-> bytes_remaining != '0)
    else $error("data phase with no bytes remaining");

endmodule

`default_nettype wire

// ===== tb/wav_scaler_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// wav_scaler_checker: result predictor and comparator for the volume scaler
// Watches the byte, result and gain channels. Every accepted byte goes through
// a local copy of the WAV header tracking and sample scaling. The expected
// result bytes are queued and each result transaction is compared against
// the oldest one.
// ----------------------------------------------------------------------------

module wav_scaler_checker (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  input  wire logic        s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,
  input  wire logic [0:0]  s_axis_tuser,
  input  wire logic        m_axis_tvalid,
  input  wire logic        m_axis_tready,
  input  wire logic [7:0]  m_axis_tdata,
  input  wire logic [0:0]  m_axis_tuser,
  input  wire logic        m_axis_tlast,
  input  wire logic        cfg_valid,
  input  wire logic        cfg_ready,
  input  wire logic [15:0] cfg_data,
  output int               fail_count,
  output int               pending
);

  import wsvs_pkg::*;

  // Local copy of the parser state
  phase_t      phase;
  logic [16:0] byte_pos;
  logic [31:0] last_four;
  logic [15:0] bits_per_sample;
  logic [15:0] ext_len;
  logic [16:0] size_pos;
  logic [31:0] samples_left;
  logic [7:0]  low_byte;
  logic        have_low;
  logic [15:0] gain;

  res_t expected_bytes[$];
  int   mismatches = 0;

  // 8-bit unsigned sample: ((x - 128) * gain) floor-shifted by 7, recentered
  function automatic logic [7:0] scale_8bit(input logic [7:0] x, input logic [15:0] v);
    int          centered;
    int          vol_i;
    int          product;
    logic [31:0] biased;
    centered = x;
    vol_i    = v;
    product  = (centered - 128) * vol_i;
    biased   = (product >>> 7) + 128;
    return biased[7:0];
  endfunction

  // 16-bit signed sample times gain / 256, truncated toward zero
  function automatic logic [15:0] scale_16bit(input logic [7:0] lo, input logic [7:0] hi,
                                              input logic [15:0] v);
    logic signed [15:0] sample;
    longint             s_l;
    longint             v_l;
    longint             q;
    logic [63:0]        q_bits;
    sample = {hi, lo};
    s_l    = sample;
    v_l    = v;
    q      = (s_l * v_l) / 256;
    q_bits = q;
    return q_bits[15:0];
  endfunction

  task restart_file;
    phase           = PH_HEADER;
    byte_pos        = '0;
    last_four       = '0;
    bits_per_sample = '0;
    ext_len         = '0;
    size_pos        = '0;
    samples_left    = '0;
    low_byte        = '0;
    have_low        = 1'b0;
  endtask

  task start_samples;
    samples_left = last_four;
    have_low     = 1'b0;
    phase        = (last_four == 32'd0) ? PH_PASS : PH_DATA;
  endtask

  task queue_result(input logic [7:0] data, input logic err, input logic last);
    res_t r;
    r.data = data;
    r.err  = err;
    r.last = last;
    expected_bytes.push_back(r);
  endtask

  // Track one file byte and queue the result bytes it produces
  task track_and_scale(input logic [7:0] b, input logic first);
    logic [16:0] p;
    int unsigned p_w;
    logic [7:0]  ob;
    logic [15:0] pair;
    logic        echo;
    if (first)
      restart_file();
    p         = byte_pos;
    p_w       = p;
    last_four = {b, last_four[31:8]};
    if (byte_pos != POS_MAX)
      byte_pos = byte_pos + 17'd1;
    ob   = b;
    echo = 1'b1;

    case (phase)
      PH_HEADER: begin
        if (p == POS_RIFF_END && last_four != MAGIC_RIFF) begin
          phase = PH_ERROR;
        end else if (p == POS_WAVE_END && last_four != MAGIC_WAVE) begin
          phase = PH_ERROR;
        end else if (p == POS_TAG_END && last_four[31:16] != FMT_PCM) begin
          phase = PH_PASS;
        end else if (p == POS_BITS_END) begin
          bits_per_sample = last_four[31:16];
        end else if (p == POS_CHUNK_END) begin
          if (last_four == MAGIC_DATA) begin
            size_pos = SIZE_AT_DATA;
            phase    = PH_SIZE;
          end else if (last_four == MAGIC_FACT) begin
            size_pos = SIZE_AT_FACT;
            phase    = PH_SIZE;
          end else begin
            ext_len = last_four[15:0];
            phase   = PH_EXT;
          end
        end
      end
      // Chunk id after the extension bytes, or the size word itself
      PH_EXT: begin
        if (p_w == int'(EXT_CHUNK_END) + int'(ext_len)) begin
          if (last_four == MAGIC_DATA) begin
            size_pos = EXT_AT_DATA + {1'b0, ext_len};
            phase    = PH_SIZE;
          end else if (last_four == MAGIC_FACT) begin
            size_pos = EXT_AT_FACT + {1'b0, ext_len};
            phase    = PH_SIZE;
          end else begin
            start_samples();
          end
        end
      end
      PH_SIZE: begin
        if (p == size_pos + SIZE_LEN_M1)
          start_samples();
      end
      PH_DATA: begin
        if (bits_per_sample[15:3] == 13'd1) begin
          ob           = scale_8bit(b, gain);
          samples_left = samples_left - 32'd1;
          if (samples_left == 32'd0)
            phase = PH_PASS;
        end else if (!have_low) begin
          // first half of a pair: held, nothing comes out yet
          low_byte     = b;
          have_low     = 1'b1;
          samples_left = samples_left - 32'd1;
          echo         = 1'b0;
        end else begin
          pair     = scale_16bit(low_byte, b, gain);
          have_low = 1'b0;
          if (samples_left != 32'd0)
            samples_left = samples_left - 32'd1;
          if (samples_left == 32'd0)
            phase = PH_PASS;
          queue_result(pair[7:0], 1'b0, 1'b0);
          queue_result(pair[15:8], 1'b0, 1'b1);
          echo = 1'b0;
        end
      end
      default: ;
    endcase

    if (echo)
      queue_result(ob, phase == PH_ERROR, 1'b1);
  endtask

  task check_result;
    res_t exp_r;
    if (expected_bytes.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: unexpected result byte %02h err %0b last %0b", $time,
                 m_axis_tdata, m_axis_tuser[0], m_axis_tlast);
    end else begin
      exp_r = expected_bytes.pop_front();
      if (m_axis_tdata !== exp_r.data || m_axis_tuser[0] !== exp_r.err ||
          m_axis_tlast !== exp_r.last) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: result mismatch, expected byte %02h err %0b last %0b,",
                   $time, exp_r.data, exp_r.err, exp_r.last,
                   " got byte %02h err %0b last %0b",
                   m_axis_tdata, m_axis_tuser[0], m_axis_tlast);
      end
    end
  endtask

  // Sample all three channels at the rising edge
  always @(posedge clk) begin
    if (rst) begin
      restart_file();
      gain = VOL_RESET;
      expected_bytes.delete();
    end else begin
      if (m_axis_tvalid && m_axis_tready)
        check_result();
      if (cfg_valid && cfg_ready)
        gain = cfg_data;
      if (s_axis_tvalid && s_axis_tready)
        track_and_scale(s_axis_tdata, s_axis_tuser[0]);
    end
    pending    <= expected_bytes.size();
    fail_count <= mismatches;
  end

endmodule

// ===== tb/tb_wav_stream_volume_scaler.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_wav_stream_volume_scaler: stimulus and verdict for the volume scaler
// Streams short directed files, then randomized WAV files of every header
// layout (data, fact, extension, bad magic, non-PCM, odd and truncated data)
// plus noise bytes, across several gain settings, with random gaps on both
// sides and one long output stall. The checker module does the comparing.
// ----------------------------------------------------------------------------

module tb_wav_stream_volume_scaler;
  import wsvs_pkg::*;

  localparam int ITEM_TARGET = 1350;
  localparam int PHASE_BYTES = 190;
  localparam int HOLD_CYCLES = 200;
  localparam int CYCLE_LIMIT = 400000;

  localparam logic [31:0] FMT_CHUNK_ID = 32'h2074_6d66;   // "fmt "

  // Chunk layout after the bits-per-sample field
  typedef enum int {
    CK_DATA,
    CK_FACT,
    CK_EXT_DATA,
    CK_EXT_FACT,
    CK_EXT_SIZE
  } layout_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'h00;   // [7:0] in_byte
  logic [0:0]  s_axis_tuser = 1'b0;    // [0] first_of_file
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;           // [7:0] out_byte
  logic [0:0]  m_axis_tuser;           // [0] header_error
  logic        m_axis_tlast;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [15:0] cfg_data = 16'h0000;

  int pending_results;
  int checker_failures;

  logic [7:0] file_bytes[$];
  int bytes_sent = 0;
  int phase_bytes = 0;
  int send_calm = 0;
  int hold_requests = 0;
  int hold_served = 0;
  int hold_left = 0;
  int stall_left = 0;
  int recv_calm = 0;
  int cycle_count = 0;

  wav_stream_volume_scaler dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data)
  );

  wav_scaler_checker checker_i (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .fail_count    (checker_failures),
    .pending       (pending_results)
  );

  // 20 ns clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Mostly no gap, often a short one, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (r < 60)
      return 0;
    else if (r < 92)
      return $urandom_range(1, 3);
    else
      return $urandom_range(8, 30);
  endfunction

  // Output side: random stalls, calm stretches, and the long hold-off
  always @(negedge clk) begin
    if (hold_served != hold_requests) begin
      hold_served = hold_requests;
      hold_left   = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      m_axis_tready <= 1'b0;
      hold_left = hold_left - 1;
    end else if (stall_left > 0) begin
      m_axis_tready <= 1'b0;
      stall_left = stall_left - 1;
    end else begin
      m_axis_tready <= 1'b1;
      if (recv_calm > 0) begin
        recv_calm = recv_calm - 1;
      end else begin
        stall_left = pick_gap();
        if ($urandom_range(39) == 0)
          recv_calm = $urandom_range(20, 80);
      end
    end
  end

  // Watchdog
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("FAIL");
    $finish;
  end

  // Called at a falling edge; returns at the falling edge after the transaction.
  // Valid stays high on return, so the caller drives something at that edge.
  task push_byte(input logic [7:0] b, input logic first);
    int gap;
    if (send_calm > 0) begin
      gap = 0;
      send_calm--;
    end else begin
      gap = pick_gap();
      if ($urandom_range(39) == 0)
        send_calm = $urandom_range(20, 80);
    end
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tvalid   <= 1'b1;
    s_axis_tdata    <= b;
    s_axis_tuser[0] <= first;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    bytes_sent++;
    phase_bytes++;
    @(negedge clk);
  endtask

  task put8(input logic [7:0] b);
    file_bytes.push_back(b);
  endtask

  task put16(input logic [15:0] w);
    put8(w[7:0]);
    put8(w[15:8]);
  endtask

  task put32(input logic [31:0] w);
    put16(w[15:0]);
    put16(w[31:16]);
  endtask

  // Sample bytes lean on the extremes now and then
  function automatic logic [7:0] sample_byte();
    case ($urandom_range(19))
      0:       return 8'h00;
      1:       return 8'hFF;
      2:       return 8'h80;
      3:       return 8'h7F;
      default: return $urandom_range(0, 255);
    endcase
  endfunction

  function automatic logic [15:0] pick_bits();
    case ($urandom_range(7))
      0:       return 16'd8;
      1:       return 16'd12;
      2:       return 16'd15;
      3:       return 16'd16;
      4:       return 16'd24;
      5:       return 16'd0;
      6:       return 16'd7;
      default: return $urandom_range(0, 65535);
    endcase
  endfunction

  // Assemble a WAV file into file_bytes
  task build_wav(input logic [15:0] tag, input logic [15:0] bits, input layout_t kind,
                 input logic [15:0] ext_len, input logic [31:0] size, input int body,
                 input int bad_magic);
    file_bytes.delete();
    put32(MAGIC_RIFF);
    put32($urandom);
    put32(MAGIC_WAVE);
    put32(FMT_CHUNK_ID);
    put32(32'd16);
    put16(tag);
    put16($urandom_range(1, 2));
    put32($urandom);
    put32($urandom);
    put16($urandom_range(0, 65535));
    put16(bits);
    case (kind)
      CK_DATA: begin
        put32(MAGIC_DATA);
        put32(size);
      end
      CK_FACT: begin
        put32(MAGIC_FACT);
        repeat (12) put8($urandom_range(0, 255));
        put32(size);
      end
      CK_EXT_DATA: begin
        put16(ext_len);
        repeat (ext_len) put8($urandom_range(0, 255));
        put32(MAGIC_DATA);
        put32(size);
      end
      CK_EXT_FACT: begin
        put16(ext_len);
        repeat (ext_len) put8($urandom_range(0, 255));
        put32(MAGIC_FACT);
        repeat (12) put8($urandom_range(0, 255));
        put32(size);
      end
      default: begin
        // the word after the extension is taken as the size
        put16(ext_len);
        repeat (ext_len) put8($urandom_range(0, 255));
        put32(size);
      end
    endcase
    repeat (body) put8(sample_byte());
    if (bad_magic == 1)
      file_bytes[$urandom_range(0, 3)] ^= $urandom_range(1, 255);
    else if (bad_magic == 2)
      file_bytes[8 + $urandom_range(0, 3)] ^= $urandom_range(1, 255);
  endtask

  task stream_file(input logic mark_first);
    for (int i = 0; i < file_bytes.size(); i++)
      push_byte(file_bytes[i], mark_first && i == 0);
  endtask

  // Random bytes with stray restart marks
  task noise_burst;
    int len;
    len = $urandom_range(1, 12);
    repeat (len) push_byte($urandom_range(0, 255), $urandom_range(7) == 0);
  endtask

  // One file; the first twelve walk through every layout in turn
  task random_file(input int n);
    int          shape;
    logic [15:0] tag;
    logic [15:0] bits;
    layout_t     kind;
    logic [15:0] ext_len;
    logic [31:0] size;
    int          body;
    int          bad;
    logic        mark;
    shape   = (n < 12) ? n : $urandom_range(0, 11);
    tag     = FMT_PCM;
    bits    = 16'd16;
    kind    = CK_DATA;
    ext_len = $urandom_range(0, 20);
    size    = $urandom_range(1, 40);
    body    = -1;
    bad     = 0;
    mark    = 1'b1;
    if (n >= 12) begin
      if ($urandom_range(1))
        bits = pick_bits();
      if ($urandom_range(19) == 0)
        mark = 1'b0;
    end
    case (shape)
      0: size = 2 * $urandom_range(1, 20);
      1: bits = 16'd8;
      2: begin
        kind = CK_FACT;
        size = 2 * $urandom_range(0, 19) + 1;
      end
      3: begin
        kind = CK_EXT_DATA;
        if (n < 12) bits = 16'd12;
      end
      4: begin
        kind = CK_EXT_FACT;
        if (n < 12) bits = 16'd24;
      end
      5: begin
        kind = CK_EXT_SIZE;
        size = $urandom_range(0, 40);
        if (n < 12) bits = $urandom_range(0, 65535);
      end
      6: begin
        tag = $urandom_range(0, 65535);
        if (tag == FMT_PCM) tag = 16'h0003;
      end
      7: bad = 1;
      8: bad = 2;
      9: size = 0;
      10: begin
        // stop inside the data on the first byte of a pair
        bits = 16'd16;
        size = $urandom_range(6, 40);
        body = 2 * $urandom_range(0, (size - 2) / 2) + 1;
      end
      default: begin
        size = {1'b1, 31'($urandom)};
        bits = $urandom_range(1) ? 16'd8 : 16'd16;
        body = $urandom_range(10, 30);
      end
    endcase
    if (body < 0)
      body = size + size[0] + $urandom_range(0, 4);
    build_wav(tag, bits, kind, ext_len, size, body, bad);
    stream_file(mark);
  endtask

  // Drop valid and wait until every expected result is out and the pipe is quiet
  task settle;
    s_axis_tvalid <= 1'b0;
    while (pending_results != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task write_gain(input logic [15:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [15:0] next_gain(input int step);
    case (step)
      0:       return 16'd0;
      1:       return 16'hFFFF;
      2:       return 16'd128;
      3:       return 16'd1;
      4:       return VOL_RESET;
      default: return $urandom_range(0, 65535);
    endcase
  endfunction

  initial begin
    int file_no;
    int gain_step;
    bit held_off;
    file_no   = 0;
    gain_step = 0;
    held_off  = 0;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // First file after reset carries no restart mark and has bad RIFF magic ("RIFX")
    file_bytes.delete();
    put32(MAGIC_RIFF ^ 32'h1E00_0000);
    put8(8'h00);
    put8(8'hFF);
    stream_file(1'b0);

    // Restarted file with bad WAVE magic ("WAVX")
    file_bytes.delete();
    put32(MAGIC_RIFF);
    put32(32'h0000_0024);
    put32(MAGIC_WAVE ^ 32'h1D00_0000);
    put8(8'h80);
    put8(8'h7F);
    stream_file(1'b1);

    // Random files, new gain every phase
    while (bytes_sent < ITEM_TARGET) begin
      if (phase_bytes >= PHASE_BYTES) begin
        settle();
        write_gain(next_gain(gain_step));
        gain_step++;
        phase_bytes = 0;
      end
      if (!held_off && bytes_sent >= 300) begin
        hold_requests <= hold_requests + 1;
        held_off = 1;
      end
      if (file_no >= 12 && $urandom_range(9) == 0)
        noise_burst();
      else
        random_file(file_no);
      file_no++;
    end

    s_axis_tvalid <= 1'b0;
    while (pending_results != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (checker_failures == 0 && pending_results == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
